FILE: sv/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared widths, opcode names and controller/datapath handshake types for
// the stack machine step engine.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int DATA_DEPTH = 1024;
	localparam int CALL_DEPTH = 256;
	localparam int DATA_WIDTH = 32;

	localparam int PC_W   = 26;
	localparam int OPND_W = 26;
	localparam int KIND_W = 4;
	localparam int TOP_W  = 32;
	localparam int DA_W   = $clog2(DATA_DEPTH);
	localparam int DC_W   = $clog2(DATA_DEPTH + 1);
	localparam int FA_W   = $clog2(CALL_DEPTH);
	localparam int FC_W   = $clog2(CALL_DEPTH + 1);
	localparam int SLOT_W = ((DC_W > OPND_W) ? DC_W : OPND_W) + 1;
	localparam int IDX_W  = ((SLOT_W > DATA_WIDTH) ? SLOT_W : DATA_WIDTH) + 2;
	localparam int FR_W   = PC_W + DC_W;

	localparam logic [KIND_W-1:0] K_SET    = 4'd0;
	localparam logic [KIND_W-1:0] K_LESS   = 4'd1;
	localparam logic [KIND_W-1:0] K_ADD    = 4'd2;
	localparam logic [KIND_W-1:0] K_SUB    = 4'd3;
	localparam logic [KIND_W-1:0] K_BORROW = 4'd4;
	localparam logic [KIND_W-1:0] K_CALL   = 4'd5;
	localparam logic [KIND_W-1:0] K_PUSH   = 4'd6;
	localparam logic [KIND_W-1:0] K_LOAD   = 4'd7;
	localparam logic [KIND_W-1:0] K_BASED  = 4'd8;
	localparam logic [KIND_W-1:0] K_CLR    = 4'd9;
	localparam logic [KIND_W-1:0] K_JIF    = 4'd10;
	localparam logic [KIND_W-1:0] K_GIF    = 4'd11;
	localparam logic [KIND_W-1:0] K_RET    = 4'd12;

	typedef struct packed {
		logic load;
		logic check;
		logic commit;
		logic refresh;
		logic latch;
		logic emit;
	} svm_cmd_t;

	typedef struct packed {
		logic fault;
		logic skip;
		logic pre;
		logic post;
	} svm_stat_t;

	function automatic logic [TOP_W-1:0] top_word(input logic [DATA_WIDTH-1:0] v);
		logic signed [DATA_WIDTH-1:0] s;
		s = $signed(v);
		return TOP_W'(s);
	endfunction

endpackage

FILE: sv/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl
// Step sequencer: check, optional stack read, commit, optional top refresh,
// then result strobe.
// ----------------------------------------------------------------------------
module svm_ctrl import svm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  svm_stat_t stat,
	output svm_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_RD     = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_REF    = 3'd4;
	localparam logic [2:0] S_LATCH  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       post_q;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (stat.fault || stat.skip) state_d = S_DONE;
				else if (stat.pre) state_d = S_RD;
				else state_d = S_COMMIT;
			end
			S_RD:     state_d = S_COMMIT;
			S_COMMIT: state_d = post_q ? S_REF : S_DONE;
			S_REF:    state_d = S_LATCH;
			S_LATCH:  state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			post_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (state_q == S_CHECK) post_q <= stat.post;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.check   = (state_q == S_CHECK);
	assign cmd.commit  = (state_q == S_COMMIT);
	assign cmd.refresh = (state_q == S_REF);
	assign cmd.latch   = (state_q == S_LATCH);
	assign cmd.emit    = (state_q == S_DONE);

endmodule

FILE: sv/svm_dpath.sv
// ----------------------------------------------------------------------------
// svm_dpath
// Machine state, data stack and frame stack memories, checks and the
// per-instruction update.
// ----------------------------------------------------------------------------
module svm_dpath import svm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  svm_cmd_t            cmd,
	output svm_stat_t           stat,
	input  logic [KIND_W-1:0]   kind,
	input  logic [OPND_W-1:0]   operand,
	input  logic                cfg_we,
	input  logic [PC_W-1:0]     cfg_data,
	output logic [PC_W-1:0]     next_pc,
	output logic signed [TOP_W-1:0] top_value,
	output logic                halted,
	output logic                fault
);

	logic [DATA_WIDTH-1:0] dmem [DATA_DEPTH];
	logic [FR_W-1:0]       fmem [CALL_DEPTH];

	logic [KIND_W-1:0]     kind_q;
	logic [OPND_W-1:0]     opnd_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [DA_W-1:0]       idx_q;
	logic                  fault_q;
	logic [DATA_WIDTH-1:0] top_q, top_d;
	logic [DATA_WIDTH-1:0] drd_q;
	logic [FR_W-1:0]       frd_q;
	logic [DC_W-1:0]       cnt_q, cnt_d;
	logic [DC_W-1:0]       base_q, base_d;
	logic [FC_W-1:0]       fcnt_q, fcnt_d;
	logic [PC_W-1:0]       pc_q, pc_d;
	logic                  halt_q, halt_d;

	logic [PC_W-1:0]       out_pc_q;
	logic [TOP_W-1:0]      out_top_q;
	logic                  out_halt_q;
	logic                  out_fault_q;

	logic                  dwe;
	logic [DA_W-1:0]       dwaddr, draddr, daddr;
	logic [DATA_WIDTH-1:0] dwdata;
	logic                  fwe;
	logic [FA_W-1:0]       faddr;

	logic [DA_W-1:0]       cnt_m1, cnt_m2;
	logic                  ge1, ge2, full, slot_ok;
	logic signed [IDX_W-1:0] slot_x, off_x, sum_x;
	logic                  sum_bad;
	logic                  bad;

	logic [DATA_WIDTH-1:0] alu_v;
	logic [PC_W-1:0]       pc_inc;
	logic [PC_W-1:0]       fret;
	logic [DC_W-1:0]       fbase;

	assign cnt_m1  = DA_W'(cnt_q - DC_W'(1));
	assign cnt_m2  = DA_W'(cnt_q - DC_W'(2));
	assign ge1     = (cnt_q != '0);
	assign ge2     = (cnt_q >= DC_W'(2));
	assign full    = (cnt_q >= DC_W'(DATA_DEPTH));
	assign slot_ok = (slot_q < SLOT_W'(DATA_DEPTH));

	assign slot_x  = IDX_W'(slot_q);
	assign off_x   = IDX_W'($signed(top_q));
	assign sum_x   = slot_x + off_x;
	assign sum_bad = sum_x[IDX_W-1] || (sum_x[IDX_W-2:0] >= (IDX_W-1)'(DATA_DEPTH));

	always_comb begin
		bad       = 1'b0;
		stat.pre  = 1'b0;
		stat.post = 1'b0;
		unique case (kind_q)
			K_SET: begin
				bad       = !ge1 || !slot_ok;
				stat.post = 1'b1;
			end
			K_LESS, K_ADD, K_SUB: begin
				bad      = !ge2;
				stat.pre = 1'b1;
			end
			K_BORROW: bad = SLOT_W'(opnd_q) > SLOT_W'(base_q);
			K_CALL:   bad = (fcnt_q >= FC_W'(CALL_DEPTH));
			K_PUSH:   bad = full;
			K_LOAD: begin
				bad      = full || !slot_ok;
				stat.pre = 1'b1;
			end
			K_BASED: begin
				bad      = !ge1 || sum_bad;
				stat.pre = 1'b1;
			end
			K_CLR:    bad = !ge1 || (base_q >= DC_W'(DATA_DEPTH));
			K_JIF, K_GIF: begin
				bad       = !ge1;
				stat.post = 1'b1;
			end
			K_RET:    stat.pre = (fcnt_q > FC_W'(1));
			default:  bad = 1'b1;
		endcase
		stat.skip  = halt_q;
		stat.fault = bad && !halt_q;
	end

	always_comb begin
		unique case (kind_q)
			K_LESS:  alu_v = DATA_WIDTH'($signed(drd_q) < $signed(top_q));
			K_ADD:   alu_v = drd_q + top_q;
			default: alu_v = drd_q - top_q;
		endcase
	end

	assign pc_inc = pc_q + PC_W'(1);
	assign fret   = frd_q[FR_W-1:DC_W];
	assign fbase  = frd_q[DC_W-1:0];

	always_comb begin
		priority if (cmd.refresh) draddr = cnt_m1;
		else if (kind_q == K_LOAD) draddr = slot_q[DA_W-1:0];
		else if (kind_q == K_BASED) draddr = idx_q;
		else draddr = cnt_m2;
	end

	always_comb begin
		dwe    = 1'b0;
		dwaddr = cnt_q[DA_W-1:0];
		dwdata = top_q;
		fwe    = 1'b0;
		cnt_d  = cnt_q;
		top_d  = top_q;
		base_d = base_q;
		fcnt_d = fcnt_q;
		pc_d   = pc_q;
		halt_d = halt_q;
		if (cfg_we) begin
			pc_d   = cfg_data;
			halt_d = 1'b0;
		end
		if (cmd.latch) top_d = drd_q;
		if (cmd.commit) begin
			pc_d = pc_inc;
			unique case (kind_q)
				K_SET: begin
					dwe    = 1'b1;
					dwaddr = slot_q[DA_W-1:0];
					cnt_d  = cnt_q - DC_W'(1);
				end
				K_LESS, K_ADD, K_SUB: begin
					dwe    = 1'b1;
					dwaddr = cnt_m2;
					dwdata = alu_v;
					top_d  = alu_v;
					cnt_d  = cnt_q - DC_W'(1);
				end
				K_BORROW: base_d = DC_W'(SLOT_W'(base_q) - SLOT_W'(opnd_q));
				K_CALL: begin
					fwe    = 1'b1;
					base_d = cnt_q;
					fcnt_d = fcnt_q + FC_W'(1);
					pc_d   = PC_W'(opnd_q);
				end
				K_PUSH: begin
					dwe    = 1'b1;
					dwdata = DATA_WIDTH'(opnd_q);
					top_d  = DATA_WIDTH'(opnd_q);
					cnt_d  = cnt_q + DC_W'(1);
				end
				K_LOAD: begin
					dwe    = 1'b1;
					dwdata = drd_q;
					top_d  = drd_q;
					cnt_d  = cnt_q + DC_W'(1);
				end
				K_BASED: begin
					dwe    = 1'b1;
					dwaddr = cnt_m1;
					dwdata = drd_q;
					top_d  = drd_q;
				end
				K_CLR: begin
					dwe    = 1'b1;
					dwaddr = base_q[DA_W-1:0];
					cnt_d  = base_q + DC_W'(1);
				end
				K_JIF: begin
					cnt_d = cnt_q - DC_W'(1);
					if (top_q == '0) pc_d = pc_q + PC_W'(opnd_q);
				end
				K_GIF: begin
					cnt_d = cnt_q - DC_W'(1);
					if (top_q != '0) pc_d = pc_q - PC_W'(opnd_q);
				end
				K_RET: begin
					if (fcnt_q <= FC_W'(1)) begin
						halt_d = 1'b1;
						pc_d   = pc_q;
					end else begin
						fcnt_d = fcnt_q - FC_W'(1);
						pc_d   = fret + PC_W'(1);
						base_d = fbase;
					end
				end
				default: pc_d = pc_q;
			endcase
		end
	end

	assign daddr = cmd.commit ? dwaddr : draddr;
	assign faddr = cmd.commit ? fcnt_q[FA_W-1:0] : FA_W'(fcnt_q - FC_W'(1));

	always_ff @(posedge clk) begin
		if (dwe) dmem[daddr] <= dwdata;
		drd_q <= dmem[daddr];
	end

	always_ff @(posedge clk) begin
		if (fwe) fmem[faddr] <= {pc_q, base_q};
		frd_q <= fmem[faddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			base_q <= '0;
			fcnt_q <= FC_W'(1);
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			base_q <= base_d;
			fcnt_q <= fcnt_d;
			pc_q   <= pc_d;
			halt_q <= halt_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (cmd.load) begin
			kind_q <= kind;
			opnd_q <= operand;
			slot_q <= SLOT_W'(base_q) + SLOT_W'(operand);
		end
		if (cmd.check) begin
			fault_q <= stat.fault;
			idx_q   <= sum_x[DA_W-1:0];
		end
		if (cmd.emit) begin
			out_pc_q    <= pc_q;
			out_top_q   <= (cnt_q == '0) ? '0 : top_word(top_q);
			out_halt_q  <= halt_q;
			out_fault_q <= fault_q;
		end
	end

	assign next_pc   = out_pc_q;
	assign top_value = $signed(out_top_q);
	assign halted    = out_halt_q;
	assign fault     = out_fault_q;

endmodule

FILE: sv/stack_vm_instruction_step.sv
// ----------------------------------------------------------------------------
// stack_vm_instruction_step
// One instruction step of a stack machine with data stack, frame stack and
// program counter.
// One step at a time; done pulses after the step has passed check, a stack
// read for steps that read an operand from a stack memory, commit and, for
// pops that refetch the top, refresh and latch; a refused step or a halted
// machine goes from check straight to done. The single-port stack memory
// sets this sequence. Busy falls with done; a start is taken in that cycle.
// Reset: empty data stack, one frame at base zero, pc zero, not halted.
// ----------------------------------------------------------------------------
module stack_vm_instruction_step import svm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [KIND_W-1:0]       kind,
	input  logic [OPND_W-1:0]       operand,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [PC_W-1:0]         cfg_data,
	output logic                    done,
	output logic [PC_W-1:0]         next_pc,
	output logic signed [TOP_W-1:0] top_value,
	output logic                    halted,
	output logic                    fault
);

	svm_cmd_t  cmd;
	svm_stat_t stat;

	assign cfg_ready = !busy;

	svm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	svm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.operand   (operand),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.next_pc   (next_pc),
		.top_value (top_value),
		.halted    (halted),
		.fault     (fault)
	);

endmodule
